// ----- src/safe_path_checker_top_defines.svh -----
// Assertion macros for the safe path checker.
// Included by safe_path_checker_top.sv; expects a clock and reset in scope.
`ifndef SAFE_PATH_CHECKER_TOP_DEFINES_SVH
`define SAFE_PATH_CHECKER_TOP_DEFINES_SVH

// same-cycle implication
`define SPC_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("safe path checker assertion failed");

// next-cycle implication
`define SPC_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("safe path checker assertion failed");

`endif

// ----- src/spc_pkg.sv -----
// Shared types and constants for the safe path checker.
// No dependencies; imported by spc_step and safe_path_checker_top.
`timescale 1ns / 1ps
`default_nettype none

package spc_pkg;

   localparam logic [7:0]  CHAR_NUL   = 8'h00;
   localparam logic [7:0]  CHAR_SLASH = 8'h2F;
   localparam logic [7:0]  CHAR_DOT   = 8'h2E;

   localparam logic [12:0] POS_SAT          = 13'd8191;
   localparam logic [12:0] PATH_MAX_RESET   = 13'd1024;
   localparam logic [7:0]  NAME_MAX_RESET   = 8'd255;

   localparam logic [2:0]  ADDR_PATH_MAX = 3'd0;
   localparam logic [2:0]  ADDR_NAME_MAX = 3'd4;

   // verdict reasons
   localparam logic [3:0]  REASON_OK          = 4'd0;
   localparam logic [3:0]  REASON_LEAD_SLASH  = 4'd1;
   localparam logic [3:0]  REASON_NAME_LONG   = 4'd2;
   localparam logic [3:0]  REASON_BAD_UTF8    = 4'd3;
   localparam logic [3:0]  REASON_DOT_SLASH   = 4'd4;
   localparam logic [3:0]  REASON_END_DOT     = 4'd5;
   localparam logic [3:0]  REASON_START_DOT   = 4'd6;
   localparam logic [3:0]  REASON_BAD_CHAR    = 4'd7;
   localparam logic [3:0]  REASON_PATH_LONG   = 4'd8;

   // allowed range of the next continuation byte
   localparam logic [2:0]  LIM_80_BF = 3'd0;
   localparam logic [2:0]  LIM_A0_BF = 3'd1;
   localparam logic [2:0]  LIM_80_9F = 3'd2;
   localparam logic [2:0]  LIM_90_BF = 3'd3;
   localparam logic [2:0]  LIM_80_8F = 3'd4;

   typedef struct packed {
      logic [12:0] byte_position;
      logic [8:0]  name_length;
      logic        after_dot;
      logic [1:0]  utf8_left;
      logic [2:0]  utf8_lim;
      logic        failed;
      logic [3:0]  first_reason;
   } spc_state_type;

   typedef struct packed {
      logic       emit;
      logic       safe;
      logic [3:0] reason;
   } spc_verdict_type;

endpackage

`default_nettype wire

// ----- src/spc_step.sv -----
// Per-word next-state logic of the safe path checker.
// Depends on spc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spc_step import spc_pkg::*; (
   input  spc_state_type   state_cur,
   input  logic [7:0]      byte_in,
   input  logic [12:0]     path_max,
   input  logic [7:0]      name_max,
   output spc_state_type   state_nxt,
   output spc_verdict_type verdict
);

   logic [12:0] pos_inc;
   logic [7:0]  lo;
   logic [7:0]  hi;
   logic        fail_hit;
   logic [3:0]  fail_why;
   spc_state_type nxt;

   assign pos_inc = (state_cur.byte_position == POS_SAT) ?
                    state_cur.byte_position : state_cur.byte_position + 13'd1;

   always_comb begin
      lo = 8'h80;
      hi = 8'hBF;
      case (state_cur.utf8_lim)
         LIM_A0_BF: lo = 8'hA0;
         LIM_80_9F: hi = 8'h9F;
         LIM_90_BF: lo = 8'h90;
         LIM_80_8F: hi = 8'h8F;
         default: ;
      endcase
   end

   always_comb begin
      nxt      = state_cur;
      fail_hit = 1'b0;
      fail_why = REASON_OK;
      if (!state_cur.failed) begin
         if (state_cur.utf8_left != 2'd0) begin
            if (byte_in < lo || byte_in > hi) begin
               fail_hit = 1'b1;
               fail_why = REASON_BAD_UTF8;
            end else begin
               nxt.utf8_left     = state_cur.utf8_left - 2'd1;
               nxt.utf8_lim      = LIM_80_BF;
               nxt.name_length   = state_cur.name_length + 9'd1;
               nxt.byte_position = pos_inc;
            end
         end else if (state_cur.byte_position == 13'd0 && byte_in == CHAR_SLASH) begin
            fail_hit = 1'b1;
            fail_why = REASON_LEAD_SLASH;
         end else if (state_cur.byte_position >= path_max) begin
            fail_hit = 1'b1;
            fail_why = REASON_PATH_LONG;
         end else if (state_cur.name_length >= {1'b0, name_max}) begin
            fail_hit = 1'b1;
            fail_why = REASON_NAME_LONG;
         end else if (byte_in[7]) begin
            nxt.name_length   = state_cur.name_length + 9'd1;
            nxt.byte_position = pos_inc;
            nxt.utf8_lim      = LIM_80_BF;
            if (byte_in inside {[8'hC2:8'hDF]}) begin
               nxt.utf8_left = 2'd1;
            end else if (byte_in inside {[8'hE0:8'hEF]}) begin
               nxt.utf8_left = 2'd2;
               if (byte_in == 8'hE0) nxt.utf8_lim = LIM_A0_BF;
               else if (byte_in == 8'hED) nxt.utf8_lim = LIM_80_9F;
            end else if (byte_in inside {[8'hF0:8'hF4]}) begin
               nxt.utf8_left = 2'd3;
               if (byte_in == 8'hF0) nxt.utf8_lim = LIM_90_BF;
               else if (byte_in == 8'hF4) nxt.utf8_lim = LIM_80_8F;
            end else begin
               nxt      = state_cur;
               fail_hit = 1'b1;
               fail_why = REASON_BAD_UTF8;
            end
         end else begin
            nxt.byte_position = pos_inc;
            if (byte_in inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                                8'h5F, 8'h2D, 8'h2B}) begin
               nxt.name_length = state_cur.name_length + 9'd1;
               nxt.after_dot   = 1'b0;
            end else if (byte_in == CHAR_SLASH) begin
               if (state_cur.after_dot) begin
                  fail_hit = 1'b1;
                  fail_why = REASON_DOT_SLASH;
               end else begin
                  nxt.name_length = 9'd0;
               end
            end else if (byte_in == CHAR_NUL) begin
               if (state_cur.after_dot) begin
                  fail_hit = 1'b1;
                  fail_why = REASON_END_DOT;
               end
            end else if (byte_in == CHAR_DOT) begin
               nxt.after_dot = 1'b1;
               if (state_cur.name_length != 9'd0) begin
                  nxt.name_length = state_cur.name_length + 9'd1;
               end else begin
                  fail_hit = 1'b1;
                  fail_why = REASON_START_DOT;
               end
            end else begin
               fail_hit = 1'b1;
               fail_why = REASON_BAD_CHAR;
            end
         end
      end
      if (fail_hit) begin
         nxt.failed       = 1'b1;
         nxt.first_reason = fail_why;
         nxt.utf8_left    = 2'd0;
         nxt.utf8_lim     = LIM_80_BF;
      end
   end

   always_comb begin
      verdict.emit   = (byte_in == CHAR_NUL);
      verdict.safe   = !nxt.failed;
      verdict.reason = nxt.first_reason;
      state_nxt      = (byte_in == CHAR_NUL) ? '0 : nxt;
   end

endmodule

`default_nettype wire

// ----- src/safe_path_checker_top.sv -----
// Safe path checker top level: handshakes, path state, registers and verdict.
// Depends on spc_pkg, spc_step and safe_path_checker_top_defines.svh.
//
// The checker takes one path byte per word and answers once per path, on the
// word that carries the terminating NUL, with safe and the first failure
// reason. One word is taken every cycle; the verdict appears in the result
// register the cycle after its NUL is taken, and req_ready drops only while
// that register holds a verdict the sink has not taken. The per-byte path
// state is updated by one level of compare and increment logic, which sets
// the clock. path_max sits at address 0 and name_max at address 4; write
// them only while no path is in progress.
`timescale 1ns / 1ps
`default_nettype none

`include "safe_path_checker_top_defines.svh"

module safe_path_checker_top import spc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_safe,
   output logic [3:0]  rsp_reason,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   spc_state_type   state_ff;
   spc_state_type   state_in;
   spc_verdict_type verdict;
   logic [12:0]     path_max_ff;
   logic [7:0]      name_max_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            rsp_safe_ff;
   logic [3:0]      rsp_reason_ff;
   logic            accept;
   logic            cfg_write;

   spc_step u_step (
      .state_cur (state_ff),
      .byte_in   (req_byte_in),
      .path_max  (path_max_ff),
      .name_max  (name_max_ff),
      .state_nxt (state_in),
      .verdict   (verdict)
   );

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = (accept && verdict.emit) ? 1'b1 :
                         (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign cfg_write    = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         path_max_ff  <= PATH_MAX_RESET;
         name_max_ff  <= NAME_MAX_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
         if (cfg_write) begin
            if (paddr[2]) name_max_ff <= pwdata[7:0];
            else path_max_ff <= pwdata[12:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && verdict.emit) begin
         rsp_safe_ff   <= verdict.safe;
         rsp_reason_ff <= verdict.reason;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_safe   = rsp_safe_ff;
   assign rsp_reason = rsp_reason_ff;
   assign pready     = 1'b1;
   assign prdata     = (paddr[2] == ADDR_NAME_MAX[2]) ? {24'd0, name_max_ff} :
                                                        {19'd0, path_max_ff};

   `SPC_ASSERT_NOW(a_reason_clear, !state_ff.failed, state_ff.first_reason == REASON_OK)
   `SPC_ASSERT_NOW(a_utf8_not_failed, state_ff.utf8_left != 2'd0, !state_ff.failed)
   `SPC_ASSERT_NOW(a_lim_in_char, state_ff.utf8_lim != LIM_80_BF, state_ff.utf8_left != 2'd0)
   `SPC_ASSERT_NEXT(a_nul_gives_verdict, accept && req_byte_in == CHAR_NUL, rsp_valid_ff)
   `SPC_ASSERT_NOW(a_verdict_match, rsp_valid_ff, rsp_safe_ff == (rsp_reason_ff == REASON_OK))

endmodule

`default_nettype wire
